### src/kda_pkg.sv
`default_nettype none
package kda_pkg;

	localparam int KEY_W = 6;
	localparam int CTR_W = 5;
	localparam int THR_W = 4;
	localparam int VAL_W = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [KEY_W-1:0] KEY_EXEMPT_A = 6'd30;
	localparam logic [KEY_W-1:0] KEY_EXEMPT_B = 6'd35;
	localparam logic [KEY_W-1:0] KEY_EXEMPT_ABOVE = 6'd40;
	localparam logic [CTR_W-1:0] CTR_MAX = 5'd31;
	localparam logic [VAL_W-1:0] RPT_MAX = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_PERIOD_SLOW = 3'd1,
		REG_PERIOD_MID = 3'd2,
		REG_PERIOD_FAST = 3'd3,
		REG_PERIOD_TOP = 3'd4,
		REG_STEP_ONE = 3'd5,
		REG_STEP_TWO = 3'd6,
		REG_STEP_THREE = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef struct packed {
		logic en;
		logic [CFG_IDX_W-1:0] idx;
		logic [VAL_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		cmd_t cmd;
		logic [KEY_W-1:0] key;
		logic pressed;
		logic rep;
	} op_t;

endpackage
`default_nettype wire

### src/kda_front.sv
`default_nettype none
module kda_front #(
	parameter int NUM_KEYS = 64
) (
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic [0:0] s_tuser,
	input wire logic q_ready,
	output logic q_push,
	output kda_pkg::op_t q_op
);
	import kda_pkg::*;

	logic [KEY_W-1:0] key;
	logic in_range;
	logic exempt;
	logic keep;

	always_comb begin
		key = s_tdata[5:0];
		q_op.cmd = cmd_t'(s_tuser[0]);
		q_op.key = key;
		q_op.pressed = s_tdata[6];
		q_op.rep = s_tdata[7];
		in_range = (32'(key) < NUM_KEYS);
		exempt = (key == KEY_EXEMPT_A) || (key == KEY_EXEMPT_B) || (key > KEY_EXEMPT_ABOVE);
		keep = (q_op.cmd == CMD_TICK) || (in_range && (!s_tdata[8] || exempt));
	end

	assign s_tready = q_ready;
	assign q_push = s_tvalid && q_ready && keep;
endmodule
`default_nettype wire

### src/kda_queue.sv
`default_nettype none
module kda_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire kda_pkg::op_t push_op,
	output logic ready,
	input wire logic pop,
	output logic valid,
	output kda_pkg::op_t head
);
	import kda_pkg::*;

	op_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_pop;

	assign ready = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_op;
	end
endmodule
`default_nettype wire

### src/kda_back.sv
`default_nettype none
module kda_back #(
	parameter int NUM_KEYS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire kda_pkg::cfg_wr_t cfg,
	input wire logic q_valid,
	input wire kda_pkg::op_t q_op,
	output logic q_pop,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata,
	output logic [0:0] m_tuser
);
	import kda_pkg::*;

	localparam int KW = $clog2(NUM_KEYS);

	logic [THR_W-1:0] thr_q;
	logic [VAL_W-1:0] period_q [4];
	logic [VAL_W-1:0] step1_q, step2_q, step3_q;

	logic [CTR_W-1:0] mem_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] valid_q;

	logic [VAL_W-1:0] rpt_q;
	logic [1:0] speed_q;
	logic [VAL_W-1:0] accel_q;

	logic valid_s1;
	op_t op_s1;
	logic [KW-1:0] idx_s1;
	logic [CTR_W-1:0] rd_s1;
	logic vld_s1;
	logic fwd_s1;
	logic [CTR_W-1:0] fwd_d_s1;

	logic out_free, adv, proc, wr_en;
	logic [KW+KEY_W-1:0] idx_wide;
	logic [KW-1:0] in_idx;
	logic [CTR_W-1:0] ctr, nc;
	logic [CTR_W-1:0] thr5;
	logic res_en, res_rel;
	logic [VAL_W-1:0] rpt_d, rpt_inc, accel_d, accel_inc;
	logic [1:0] speed_d;

	assign out_free = !m_tvalid || m_tready;
	assign adv = !valid_s1 || out_free;
	assign proc = valid_s1 && out_free;
	assign q_pop = adv;
	assign wr_en = proc && (op_s1.cmd == CMD_SAMPLE);
	assign idx_wide = {{KW{1'b0}}, q_op.key};
	assign in_idx = idx_wide[KW-1:0];
	assign thr5 = {1'b0, thr_q};

	always_comb begin
		ctr = fwd_s1 ? fwd_d_s1 : (vld_s1 ? rd_s1 : '0);
		nc = ctr;
		res_en = 1'b0;
		res_rel = 1'b0;
		rpt_d = rpt_q;
		speed_d = speed_q;
		accel_d = accel_q;
		rpt_inc = (rpt_q != RPT_MAX) ? rpt_q + 8'd1 : rpt_q;
		accel_inc = accel_q + 8'd1;
		if (op_s1.cmd == CMD_TICK) begin
			if (rpt_q != '0 && accel_q != step3_q) begin
				accel_d = accel_inc;
				if (accel_inc == step1_q)
					speed_d = 2'd1;
				if (accel_inc == step2_q)
					speed_d = 2'd2;
				if (accel_inc == step3_q)
					speed_d = 2'd3;
			end
		end else if (!op_s1.rep) begin
			if (op_s1.pressed) begin
				if (ctr < thr5) begin
					nc = ctr + 5'd1;
					res_en = (nc == thr5);
				end
			end else if (ctr != '0) begin
				nc = ctr - 5'd1;
				res_en = (nc == '0);
				res_rel = res_en;
			end
		end else if (!op_s1.pressed) begin
			nc = '0;
		end else begin
			nc = (ctr != CTR_MAX) ? ctr + 5'd1 : ctr;
			if (nc == thr5) begin
				rpt_d = '0;
				speed_d = 2'd0;
				accel_d = '0;
				res_en = 1'b1;
			end else if (rpt_inc >= period_q[speed_q]) begin
				rpt_d = '0;
				res_en = 1'b1;
			end else begin
				rpt_d = rpt_inc;
			end
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 4'd3;
			period_q[0] <= 8'd15;
			period_q[1] <= 8'd7;
			period_q[2] <= 8'd4;
			period_q[3] <= 8'd1;
			step1_q <= 8'd50;
			step2_q <= 8'd100;
			step3_q <= 8'd200;
		end else if (cfg.en) begin
			unique case (cfg_reg_t'(cfg.idx))
				REG_THRESHOLD: thr_q <= cfg.data[THR_W-1:0];
				REG_PERIOD_SLOW: period_q[0] <= cfg.data;
				REG_PERIOD_MID: period_q[1] <= cfg.data;
				REG_PERIOD_FAST: period_q[2] <= cfg.data;
				REG_PERIOD_TOP: period_q[3] <= cfg.data;
				REG_STEP_ONE: step1_q <= cfg.data;
				REG_STEP_TWO: step2_q <= cfg.data;
				REG_STEP_THREE: step3_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// control and global state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q <= '0;
			rpt_q <= '0;
			speed_q <= '0;
			accel_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv)
				valid_s1 <= q_valid;
			if (wr_en)
				valid_q[idx_s1] <= 1'b1;
			if (proc) begin
				rpt_q <= rpt_d;
				speed_q <= speed_d;
				accel_q <= accel_d;
			end
			if (proc && res_en)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	// key counter memory, stage 1 payload and output payload
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[idx_s1] <= nc;
		if (adv) begin
			op_s1 <= q_op;
			idx_s1 <= in_idx;
			rd_s1 <= mem_q[in_idx];
			vld_s1 <= valid_q[in_idx];
			fwd_s1 <= wr_en && (idx_s1 == in_idx);
			fwd_d_s1 <= nc;
		end
		if (proc && res_en) begin
			m_tdata <= {2'b00, op_s1.key};
			m_tuser <= res_rel;
		end
	end
endmodule
`default_nettype wire

### src/key_debounce_autorepeat_core.sv
`default_nettype none
// Path: a key sample request is written to the queue at the accepting edge, then its counter
// memory read fills stage 1, and execute writes the output register that offers its event.
// Throughput: one request per cycle while the output is not stalled; the counter read-modify-write has a bypass.
// Reset: arst_n clears counters (per-key valid bits), repeat/speed/accel state,
// the queue and the output; configuration returns to its default values.
module key_debounce_autorepeat_core #(
	parameter int NUM_KEYS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [15:0] s_tdata, // key_number[5:0], pressed[6], repeat_mode[7], block_active[8]
	input wire logic [0:0] s_tuser, // command[0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // event_key[5:0]
	output logic [0:0] m_tuser, // is_release[0]
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [7:0] cfg_data
);
	import kda_pkg::*;

	logic q_ready, q_push, q_valid, q_pop;
	op_t push_op, head_op;
	cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.en = cfg_valid;
	assign cfg.idx = cfg_index;
	assign cfg.data = cfg_data;

	kda_front #(.NUM_KEYS(NUM_KEYS)) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_ready(q_ready),
		.q_push(q_push),
		.q_op(push_op)
	);

	kda_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_op(push_op),
		.ready(q_ready),
		.pop(q_pop),
		.valid(q_valid),
		.head(head_op)
	);

	kda_back #(.NUM_KEYS(NUM_KEYS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_op(head_op),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);
endmodule
`default_nettype wire
